[src/uds_pkg.sv]
// Shared types and constants for the UTF-8 stream decoder.
// Used by uds_front, uds_queue, uds_back and utf8_stream_decoder.
package uds_pkg;

  // Width of the saturating character counter (8 to 32).
  localparam int CountBits = 32;
  localparam logic [CountBits-1:0] CountMax = {CountBits{1'b1}};

  // Byte queue between the front and back parts.
  localparam int QueueDepth = 2;
  localparam int QueuePtrW  = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int QueueCntW  = $clog2(QueueDepth + 1);

  // Result kind codes.
  localparam logic [1:0] KindChar      = 2'd0;
  localparam logic [1:0] KindEndOk     = 2'd1;
  localparam logic [1:0] KindMalformed = 2'd2;
  localparam logic [1:0] KindEndErr    = 2'd3;

  // Byte classes decided by the front part.
  typedef enum logic [2:0] {
    CLS_NUL,
    CLS_ASCII,
    CLS_CONT,
    CLS_LEAD,
    CLS_BAD
  } byte_cls_t;

  // One classified byte.
  typedef struct packed {
    byte_cls_t   cls;
    logic [2:0]  len;   // continuation bytes expected after a lead
    logic [6:0]  bits;  // ASCII value, lead payload or continuation payload
  } byte_class_t;

  // Queue status toward the front and back parts and the top level.
  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

endpackage

[src/uds_front.sv]
// Front part: accepts raw bytes and classifies them for the back part.
// Depends on uds_pkg.
module uds_front (
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           in_byte_value,
  input  uds_pkg::queue_stat_t q_stat,
  output logic                 push,
  output uds_pkg::byte_class_t push_data
);

  logic [7:0] b;

  assign b        = in_byte_value;
  assign in_ready = !q_stat.full;
  assign push     = in_valid && !q_stat.full;

  // Classify the byte and mask the lead payload.
  always_comb begin
    push_data.cls  = uds_pkg::CLS_BAD;
    push_data.len  = 3'd0;
    push_data.bits = 7'd0;
    if (b == 8'h00) begin
      push_data.cls = uds_pkg::CLS_NUL;
    end else if (b < 8'h80) begin
      push_data.cls  = uds_pkg::CLS_ASCII;
      push_data.bits = b[6:0];
    end else if (b[7:6] == 2'b10) begin
      push_data.cls  = uds_pkg::CLS_CONT;
      push_data.bits = {1'b0, b[5:0]};
    end else if (b < 8'hC2 || b >= 8'hFE) begin
      push_data.cls = uds_pkg::CLS_BAD;
    end else if (b < 8'hE0) begin
      push_data.cls  = uds_pkg::CLS_LEAD;
      push_data.len  = 3'd1;
      push_data.bits = {2'b00, b[4:0]};
    end else if (b < 8'hF0) begin
      push_data.cls  = uds_pkg::CLS_LEAD;
      push_data.len  = 3'd2;
      push_data.bits = {2'b00, b[4:0]};
    end else if (b < 8'hF8) begin
      push_data.cls  = uds_pkg::CLS_LEAD;
      push_data.len  = 3'd3;
      push_data.bits = {4'd0, b[2:0]};
    end else if (b < 8'hFC) begin
      push_data.cls  = uds_pkg::CLS_LEAD;
      push_data.len  = 3'd4;
      push_data.bits = {5'd0, b[1:0]};
    end else begin
      push_data.cls  = uds_pkg::CLS_LEAD;
      push_data.len  = 3'd5;
      push_data.bits = {6'd0, b[0]};
    end
  end

endmodule

[src/uds_queue.sv]
// Short queue of classified bytes between the front and back parts.
// Depends on uds_pkg.
module uds_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  uds_pkg::byte_class_t push_data,
  input  logic                 pop,
  output uds_pkg::byte_class_t pop_data,
  output uds_pkg::queue_stat_t stat
);

  uds_pkg::byte_class_t          mem_r [uds_pkg::QueueDepth];
  logic [uds_pkg::QueuePtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [uds_pkg::QueuePtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [uds_pkg::QueueCntW-1:0] cnt_r, cnt_nxt;

  localparam logic [uds_pkg::QueuePtrW-1:0] LastPtr =
    uds_pkg::QueuePtrW'(uds_pkg::QueueDepth - 1);
  localparam logic [uds_pkg::QueueCntW-1:0] FullCnt =
    uds_pkg::QueueCntW'(uds_pkg::QueueDepth);

  assign stat.full  = (cnt_r == FullCnt);
  assign stat.empty = (cnt_r == '0);
  assign pop_data   = mem_r[rd_ptr_r];

  // Advance pointers and count.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LastPtr) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LastPtr) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store the pushed item.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

[src/uds_back.sv]
// Back part: decoding state, saturating count and the result register.
// Depends on uds_pkg.
module uds_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  uds_pkg::queue_stat_t           q_stat,
  input  uds_pkg::byte_class_t           pop_data,
  output logic                           pop,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [30:0]                    out_code_point,
  output logic [1:0]                     out_kind,
  output logic [31:0]                    out_char_count
);

  logic [2:0]                  pend_r, pend_nxt;
  logic [30:0]                 part_r, part_nxt;
  logic                        err_r, err_nxt;
  logic [uds_pkg::CountBits-1:0] cnt_r, cnt_nxt;
  logic                        ov_r, ov_nxt;
  logic [30:0]                 cp_r, cp_nxt;
  logic [1:0]                  kind_r, kind_nxt;
  logic [uds_pkg::CountBits-1:0] oc_r, oc_nxt;
  logic                        emit;
  logic [uds_pkg::CountBits-1:0] cnt_inc;
  logic [30:0]                 part_sh;

  // Take an item when the result register is free or being emptied.
  assign pop     = !q_stat.empty && (!ov_r || out_ready);
  assign cnt_inc = (cnt_r == uds_pkg::CountMax) ? cnt_r : cnt_r + 1'b1;
  assign part_sh = {part_r[24:0], pop_data.bits[5:0]};

  // Decode one classified byte.
  always_comb begin
    pend_nxt = pend_r;
    part_nxt = part_r;
    err_nxt  = err_r;
    cnt_nxt  = cnt_r;
    emit     = 1'b0;
    cp_nxt   = 31'd0;
    kind_nxt = uds_pkg::KindChar;
    oc_nxt   = cnt_r;
    if (pop_data.cls == uds_pkg::CLS_NUL) begin
      emit     = 1'b1;
      kind_nxt = (err_r || pend_r != 3'd0) ? uds_pkg::KindEndErr : uds_pkg::KindEndOk;
      pend_nxt = 3'd0;
      part_nxt = 31'd0;
      err_nxt  = 1'b0;
      cnt_nxt  = '0;
    end else if (err_r) begin
      emit = 1'b0;
    end else if (pend_r != 3'd0) begin
      if (pop_data.cls != uds_pkg::CLS_CONT) begin
        emit     = 1'b1;
        kind_nxt = uds_pkg::KindMalformed;
        err_nxt  = 1'b1;
        pend_nxt = 3'd0;
        part_nxt = 31'd0;
      end else begin
        pend_nxt = pend_r - 3'd1;
        if (pend_r == 3'd1) begin
          emit     = 1'b1;
          cp_nxt   = part_sh;
          cnt_nxt  = cnt_inc;
          oc_nxt   = cnt_inc;
          part_nxt = 31'd0;
        end else begin
          part_nxt = part_sh;
        end
      end
    end else begin
      case (pop_data.cls)
        uds_pkg::CLS_ASCII: begin
          emit    = 1'b1;
          cp_nxt  = {24'd0, pop_data.bits};
          cnt_nxt = cnt_inc;
          oc_nxt  = cnt_inc;
        end
        uds_pkg::CLS_LEAD: begin
          pend_nxt = pop_data.len;
          part_nxt = {24'd0, pop_data.bits};
        end
        default: begin
          emit     = 1'b1;
          kind_nxt = uds_pkg::KindMalformed;
          err_nxt  = 1'b1;
        end
      endcase
    end
  end

  // Hold the result until taken; load a new one on a producing pop.
  always_comb begin
    ov_nxt = ov_r;
    if (out_ready) begin
      ov_nxt = 1'b0;
    end
    if (pop && emit) begin
      ov_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 3'd0;
      part_r <= 31'd0;
      err_r  <= 1'b0;
      cnt_r  <= '0;
      ov_r   <= 1'b0;
    end else begin
      ov_r <= ov_nxt;
      if (pop) begin
        pend_r <= pend_nxt;
        part_r <= part_nxt;
        err_r  <= err_nxt;
        cnt_r  <= cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      cp_r   <= cp_nxt;
      kind_r <= kind_nxt;
      oc_r   <= oc_nxt;
    end
  end

  assign out_valid      = ov_r;
  assign out_code_point = cp_r;
  assign out_kind       = kind_r;
  assign out_char_count = 32'(oc_r);

endmodule

[src/utf8_stream_decoder.sv]
// Top level of the UTF-8 stream decoder: front, queue and back parts.
// Depends on uds_pkg, uds_front, uds_queue and uds_back.
//
//   channel | direction | ports
//   --------+-----------+-----------------------------------------------
//   in      | input     | in_valid, in_ready, in_byte_value
//   out     | output    | out_valid, out_ready, out_code_point, out_kind,
//           |           | out_char_count
//
// One byte per cycle sustained unless out_ready stalls the result register;
// a taken byte is queued, then decoded into the result register when popped.
// A two-entry queue parts input from decoding; in_ready drops only when it is
// full, which happens when the result register is stalled by out_ready.
// Synchronous active-low reset clears the queue, decode state and count.
module utf8_stream_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [30:0] out_code_point,
  output logic [1:0]  out_kind,
  output logic [31:0] out_char_count
);

  uds_pkg::queue_stat_t q_stat;
  uds_pkg::byte_class_t push_data;
  uds_pkg::byte_class_t pop_data;
  logic                 push;
  logic                 pop;

  uds_front u_front (
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_byte_value (in_byte_value),
    .q_stat        (q_stat),
    .push          (push),
    .push_data     (push_data)
  );

  uds_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .stat      (q_stat)
  );

  uds_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_stat         (q_stat),
    .pop_data       (pop_data),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_code_point (out_code_point),
    .out_kind       (out_kind),
    .out_char_count (out_char_count)
  );

`ifndef NO_ASSERTIONS
  // Back part must not take an item while its result is stalled.
  a_no_pop_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |-> !pop)
    else $error("item taken while result stalled");

  // Queue is never popped empty.
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty)
    else $error("pop from empty queue");

  // Non-character results carry a zero code point.
  a_zero_cp: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind != uds_pkg::KindChar) |-> (out_code_point == 31'd0))
    else $error("nonzero code point on non-character result");
`endif

endmodule

[bench/tb_utf8_stream_decoder.sv]
// Self-checking bench for utf8_stream_decoder: directed and random byte strings,
// an in-bench decode predictor, and random stalls on both handshakes.
// Depends on uds_pkg and the utf8_stream_decoder RTL.
module tb_utf8_stream_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RandomBytes = 1200;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned MaxReports  = 10;
  localparam int unsigned DrainCycles = 8;

  // Byte ranges of the lead classes
  localparam logic [7:0] AsciiTop  = 8'h7f;
  localparam logic [7:0] LeadTwo   = 8'hc2;
  localparam logic [7:0] LeadThree = 8'he0;
  localparam logic [7:0] LeadFour  = 8'hf0;
  localparam logic [7:0] LeadFive  = 8'hf8;
  localparam logic [7:0] LeadSix   = 8'hfc;
  localparam logic [7:0] LeadBadHi = 8'hfe;
  localparam logic [1:0] ContTag   = 2'b10;

  typedef struct packed {
    logic [30:0] code_point;
    logic [1:0]  kind;
    logic [31:0] char_count;
  } decode_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_byte_value;
  logic        out_valid;
  logic        out_ready;
  logic [30:0] out_code_point;
  logic [1:0]  out_kind;
  logic [31:0] out_char_count;

  // Predictor state
  logic [2:0]                    conts_left;
  logic [30:0]                   partial_cp;
  logic                          string_bad;
  logic [uds_pkg::CountBits-1:0] char_total;

  logic [7:0]     byte_q[$];
  decode_result_t decoded_q[$];

  int unsigned total_bytes;
  int unsigned taken_count;
  int unsigned mismatch_count;
  int unsigned cycle_count;
  logic        byte_taken;

  utf8_stream_decoder DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_byte_value  (in_byte_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_code_point (out_code_point),
    .out_kind       (out_kind),
    .out_char_count (out_char_count)
  );

  always #2 clk = ~clk;

  // Queue one expected result with the current character total
  task automatic push_result(input logic [30:0] cp, input logic [1:0] kind);
    decode_result_t r;
    r.code_point = cp;
    r.kind       = kind;
    r.char_count = 32'(char_total);
    decoded_q.push_back(r);
  endtask

  // Advance the decode predictor by one accepted byte
  task automatic decode_byte(input logic [7:0] b);
    if (b == 8'h00) begin
      push_result('0, (string_bad || conts_left != 0) ?
                      uds_pkg::KindEndErr : uds_pkg::KindEndOk);
      conts_left = '0;
      partial_cp = '0;
      string_bad = 1'b0;
      char_total = '0;
    end else if (string_bad) begin
      // drop everything until the terminator
    end else if (conts_left != 0) begin
      if (b[7:6] != ContTag) begin
        string_bad = 1'b1;
        conts_left = '0;
        partial_cp = '0;
        push_result('0, uds_pkg::KindMalformed);
      end else begin
        partial_cp = {partial_cp[24:0], b[5:0]};
        conts_left = conts_left - 3'd1;
        if (conts_left == 0) begin
          if (char_total != uds_pkg::CountMax) char_total = char_total + 1'b1;
          push_result(partial_cp, uds_pkg::KindChar);
          partial_cp = '0;
        end
      end
    end else if (b <= AsciiTop) begin
      if (char_total != uds_pkg::CountMax) char_total = char_total + 1'b1;
      push_result(31'(b), uds_pkg::KindChar);
    end else if (b < LeadTwo || b >= LeadBadHi) begin
      string_bad = 1'b1;
      push_result('0, uds_pkg::KindMalformed);
    end else if (b < LeadThree) begin
      conts_left = 3'd1;
      partial_cp = 31'(b & 8'h1f);
    end else if (b < LeadFour) begin
      conts_left = 3'd2;
      partial_cp = 31'(b & 8'h1f);
    end else if (b < LeadFive) begin
      conts_left = 3'd3;
      partial_cp = 31'(b & 8'h07);
    end else if (b < LeadSix) begin
      conts_left = 3'd4;
      partial_cp = 31'(b & 8'h03);
    end else begin
      conts_left = 3'd5;
      partial_cp = 31'(b & 8'h01);
    end
  endtask

  // Lead byte for a sequence of len bytes, payload random
  function automatic logic [7:0] rand_lead(input int unsigned len);
    case (len)
      2:       rand_lead = 8'($urandom_range(LeadTwo, LeadThree - 1));
      3:       rand_lead = 8'($urandom_range(LeadThree, LeadFour - 1));
      4:       rand_lead = 8'($urandom_range(LeadFour, LeadFive - 1));
      5:       rand_lead = 8'($urandom_range(LeadFive, LeadSix - 1));
      default: rand_lead = 8'($urandom_range(LeadSix, LeadBadHi - 1));
    endcase
  endfunction

  function automatic logic [7:0] rand_cont();
    rand_cont = {ContTag, 6'($urandom)};
  endfunction

  // Nonzero byte that is not a continuation
  function automatic logic [7:0] rand_non_cont();
    if ($urandom_range(0, 1) == 0) rand_non_cont = 8'($urandom_range(1, AsciiTop));
    else rand_non_cont = 8'($urandom_range(8'hc0, 8'hff));
  endfunction

  // Sequence length skewed toward short characters
  function automatic int unsigned rand_len();
    int unsigned r;
    r = $urandom_range(0, 15);
    if (r < 6) rand_len = 1;
    else if (r < 9) rand_len = 2;
    else if (r < 12) rand_len = 3;
    else if (r < 14) rand_len = 4;
    else if (r < 15) rand_len = 5;
    else rand_len = 6;
  endfunction

  // Append one well-formed character
  task automatic add_char();
    int unsigned len;
    len = rand_len();
    if (len == 1) begin
      byte_q.push_back(8'($urandom_range(1, AsciiTop)));
    end else begin
      byte_q.push_back(rand_lead(len));
      repeat (len - 1) byte_q.push_back(rand_cont());
    end
  endtask

  // Append one string: mostly clean, some with a bad lead, a bad
  // continuation or a sequence cut short by the terminator
  task automatic add_string();
    int unsigned nchars;
    int unsigned mode;
    int unsigned len;
    nchars = $urandom_range(0, 10);
    mode   = $urandom_range(0, 9);
    repeat (nchars) add_char();
    if (mode == 7) begin
      if ($urandom_range(0, 3) == 0) byte_q.push_back(8'($urandom_range(LeadBadHi, 8'hff)));
      else byte_q.push_back(8'($urandom_range(8'h80, LeadTwo - 1)));
    end else if (mode >= 8) begin
      len = $urandom_range(2, 6);
      byte_q.push_back(rand_lead(len));
      repeat ($urandom_range(0, len - 2)) byte_q.push_back(rand_cont());
      if (mode == 8) byte_q.push_back(rand_non_cont());
    end
    // trailing noise after a fault is ignored up to the terminator
    if (mode == 7 || mode == 8) begin
      repeat ($urandom_range(0, 3)) byte_q.push_back(8'($urandom_range(1, 255)));
    end
    byte_q.push_back(8'h00);
  endtask

  // Stimulus, reset and end of run
  initial begin
    clk           = 1'b0;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_byte_value = 8'h00;
    out_ready     = 1'b0;
    byte_taken    = 1'b0;
    conts_left    = '0;
    partial_cp    = '0;
    string_bad    = 1'b0;
    char_total    = '0;

    // empty string, top ASCII value, longest two-, four- and six-byte values
    byte_q = '{8'h00, 8'h7f, 8'hdf, 8'hbf, 8'hf7, 8'hbf, 8'hbf, 8'hbf,
               8'hfd, 8'hbf, 8'hbf, 8'hbf, 8'hbf, 8'hbf, 8'h00,
               // bad lead, ignored byte, terminator after error
               8'h80, 8'h41, 8'h00,
               // bad continuation
               8'hc2, 8'h41, 8'h00,
               // terminator inside a sequence
               8'he0, 8'h80, 8'h00,
               // top bad lead
               8'hff, 8'h00};
    while (byte_q.size() < RandomBytes + 26) add_string();
    total_bytes = byte_q.size();

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // drain: all bytes sent, all results seen, then allow stray results
    @(posedge clk);
    while (byte_q.size() != 0 || in_valid || decoded_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (decoded_q.size() != 0) $display("%0d results never arrived", decoded_q.size());
    if (mismatch_count == 0 && decoded_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Drive bytes and receiver stalls at the falling edge; idle rates by phase
  always @(negedge clk) begin
    int unsigned send_idle;
    int unsigned recv_idle;
    if (rst_n) begin
      if (taken_count < total_bytes / 3) begin
        send_idle = 25;
        recv_idle = 68;
      end else if (taken_count < 2 * total_bytes / 3) begin
        send_idle = 68;
        recv_idle = 25;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      out_ready <= ($urandom_range(0, 99) >= recv_idle);
      if (!in_valid || byte_taken) begin
        if (byte_q.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
          in_valid      <= 1'b1;
          in_byte_value <= byte_q.pop_front();
        end else begin
          in_valid      <= 1'b0;
          in_byte_value <= 8'($urandom);
        end
      end
    end
  end

  // Sample both handshakes at the rising edge; predict and compare
  always @(posedge clk) begin
    decode_result_t want;
    if (rst_n) begin
      byte_taken <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        decode_byte(in_byte_value);
        taken_count++;
      end
      if (out_valid && out_ready) begin
        if (decoded_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MaxReports)
            $display("unexpected result: code=%h kind=%0d count=%0d",
                     out_code_point, out_kind, out_char_count);
        end else begin
          want = decoded_q.pop_front();
          if (out_code_point !== want.code_point || out_kind !== want.kind ||
              out_char_count !== want.char_count) begin
            mismatch_count++;
            if (mismatch_count <= MaxReports)
              $display({"mismatch: exp code=%h kind=%0d count=%0d, ",
                        "got code=%h kind=%0d count=%0d"},
                       want.code_point, want.kind, want.char_count,
                       out_code_point, out_kind, out_char_count);
          end
        end
      end
    end
  end

  // Hard stop on a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("status: fail");
      $finish;
    end
  end

endmodule
